// ===== design/bezier_curve_evaluator_macros.svh =====
// Assertion macros shared by the checker of the Bezier curve evaluator.
// Each macro expands to one labelled concurrent assertion on a clock and
// an active-low synchronous reset.
`ifndef BEZIER_CURVE_EVALUATOR_MACROS_SVH
`define BEZIER_CURVE_EVALUATOR_MACROS_SVH

// Implication in the same cycle.
`define BCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define BCE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bce_pkg.sv =====
// Package of the Bezier curve evaluator: widths, codes, types and helpers.
// Used by every module of the block; depends on nothing else.
package bce_pkg;

    localparam int MAX_DEGREE = 7;
    localparam int COORD_BITS = 32;
    localparam int NSLOTS     = MAX_DEGREE + 1;
    localparam int W_IDX      = $clog2(NSLOTS);
    localparam int W_CNT      = $clog2(NSLOTS + 1);

    localparam int W_FUNC  = 3;
    localparam int W_PIDX  = 3;
    localparam int W_DEG   = 3;
    localparam int W_T     = 17;
    localparam int W_OUT   = 48;
    localparam int W_COORD = COORD_BITS;
    localparam int FRAC    = 16;

    // Forward differences up to third order grow by at most three bits.
    localparam int W_Q     = W_COORD + 4;
    localparam int W_MA    = W_Q + 1;
    localparam int W_SCALE = 12;
    localparam int W_MB    = W_T + 1;
    localparam int W_P     = W_MA + W_MB;

    localparam logic [W_T-1:0] T_ONE = W_T'(1 << FRAC);
    localparam logic [W_P-1:0] ROUND_HALF = W_P'(1 << (FRAC - 1));
    localparam logic [W_DEG-1:0] DEGREE_RESET = W_DEG'(3);
    localparam logic [W_DEG-1:0] DEGREE_MIN   = W_DEG'(2);

    localparam logic signed [W_OUT-1:0] OUT_MAX = {1'b0, {(W_OUT - 1){1'b1}}};
    localparam logic signed [W_OUT-1:0] OUT_MIN = {1'b1, {(W_OUT - 1){1'b0}}};

    localparam logic [W_FUNC-1:0] FUNC_LOAD = 3'd0;
    localparam logic [W_FUNC-1:0] FUNC_POS  = 3'd1;
    localparam logic [W_FUNC-1:0] FUNC_D1   = 3'd2;
    localparam logic [W_FUNC-1:0] FUNC_D2   = 3'd3;
    localparam logic [W_FUNC-1:0] FUNC_D3   = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PASS,
        S_DIFF,
        S_LMUL,
        S_LADD,
        S_DROP,
        S_SMUL,
        S_SAT,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        Q_HOLD,
        Q_LOAD,
        Q_DIFF,
        Q_LERP,
        Q_DROP,
        Q_SAT
    } t_qop;

    typedef enum logic {
        M_LERP,
        M_SCALE
    } t_msel;

    typedef struct packed {
        t_qop             qop;
        t_msel            msel;
        logic [1:0]       axis;
        logic [W_IDX-1:0] widx;
        logic [W_IDX-1:0] raddr;
        logic             out_load;
        logic             out_zero;
    } t_ctrl;

    // Derivative scale: 1, n, n(n-1) or n(n-1)(n-2).
    function automatic logic [W_SCALE-1:0] f_scale(input logic [W_DEG-1:0] n,
                                                   input logic [1:0] k);
        logic [W_SCALE-1:0] a;
        logic [W_SCALE-1:0] b;
        logic [W_SCALE-1:0] c;
        a = W_SCALE'(n);
        b = a - W_SCALE'(1);
        c = a - W_SCALE'(2);
        case (k)
            2'd0:    f_scale = W_SCALE'(1);
            2'd1:    f_scale = a;
            2'd2:    f_scale = a * b;
            default: f_scale = a * b * c;
        endcase
    endfunction

endpackage

// ===== design/bezier_curve_evaluator.sv =====
// Bezier curve evaluator, top level. Load and unknown items leave it ready.
// An evaluate item keeps it busy, paced by the one shared multiplier:
// a multiply state and an add state per interpolation step, plus a load
// sweep and a scale step for each axis.
// Reset (i_rst_n low, synchronous) empties the output and sets degree 3.
// Depends on bce_pkg, bce_store, bce_mul, bce_queue and bce_seq.
module bezier_curve_evaluator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bce_pkg::W_DEG-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [bce_pkg::W_FUNC-1:0]        i_func,
    input  logic [bce_pkg::W_PIDX-1:0]        i_point_index,
    input  logic signed [31:0]                i_coord_x,
    input  logic signed [31:0]                i_coord_y,
    input  logic signed [31:0]                i_coord_z,
    input  logic [bce_pkg::W_T-1:0]           i_param_t,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [bce_pkg::W_OUT-1:0]  o_out_x,
    output logic signed [bce_pkg::W_OUT-1:0]  o_out_y,
    output logic signed [bce_pkg::W_OUT-1:0]  o_out_z,
    output logic                              o_saturated
);
    import bce_pkg::*;

    // The curve degree register. Values outside the supported range are
    // clamped by the sequencer when an evaluate item is taken.
    logic [W_DEG-1:0] r_curve_degree;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_degree <= DEGREE_RESET;
        end else if (i_cfg_we) begin
            r_curve_degree <= i_cfg_data;
        end
    end

    // A load item writes the store directly in the cycle it is accepted, so
    // the block is ready again straight away. Slots beyond the highest
    // supported degree are ignored.
    logic in_accept;
    logic store_we;

    assign in_accept = i_in_valid && o_in_ready;
    assign store_we  = in_accept && (i_func == FUNC_LOAD)
                       && (i_point_index <= W_PIDX'(MAX_DEGREE));

    t_ctrl                     ctrl;
    logic signed [W_COORD-1:0] rdata;
    logic signed [W_P-1:0]     prod;
    logic signed [W_Q-1:0]     q0;
    logic signed [W_MA-1:0]    qd;
    logic [W_T-1:0]            t_val;
    logic [W_SCALE-1:0]        scale;
    logic signed [W_OUT-1:0]   res_x;
    logic signed [W_OUT-1:0]   res_y;
    logic signed [W_OUT-1:0]   res_z;
    logic                      res_sat;
    logic                      out_free;

    bce_store u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (W_IDX'(i_point_index)),
        .i_wx    (W_COORD'(i_coord_x)),
        .i_wy    (W_COORD'(i_coord_y)),
        .i_wz    (W_COORD'(i_coord_z)),
        .i_raddr (ctrl.raddr),
        .i_raxis (ctrl.axis),
        .o_rdata (rdata)
    );

    // One multiplier serves both the interpolation steps and the final
    // derivative scaling; its product is registered before it is used.
    bce_mul u_mul (
        .i_clk   (i_clk),
        .i_sel   (ctrl.msel),
        .i_d     (qd),
        .i_q0    (q0),
        .i_t     (t_val),
        .i_scale (scale),
        .o_prod  (prod)
    );

    bce_queue u_queue (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_rdata (rdata),
        .i_prod  (prod),
        .o_q0    (q0),
        .o_d     (qd),
        .o_res_x (res_x),
        .o_res_y (res_y),
        .o_res_z (res_z),
        .o_sat   (res_sat)
    );

    bce_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_param_t  (i_param_t),
        .i_degree   (r_curve_degree),
        .i_out_free (out_free),
        .o_ctrl     (ctrl),
        .o_t        (t_val),
        .o_scale    (scale)
    );

    // Output register. A finished result waits here until it is taken,
    // while the block goes back to idle and accepts the next item. A third
    // derivative on a quadratic curve is reported as zero without any work.
    logic                    r_out_valid;
    logic signed [W_OUT-1:0] r_out_x;
    logic signed [W_OUT-1:0] r_out_y;
    logic signed [W_OUT-1:0] r_out_z;
    logic                    r_out_sat;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_x   <= ctrl.out_zero ? '0 : res_x;
            r_out_y   <= ctrl.out_zero ? '0 : res_y;
            r_out_z   <= ctrl.out_zero ? '0 : res_z;
            r_out_sat <= ctrl.out_zero ? 1'b0 : res_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_saturated = r_out_sat;

endmodule

// ===== design/bce_store.sv =====
// Control point store: one memory per axis, one write and one registered read.
// Depends on bce_pkg.
module bce_store (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [bce_pkg::W_IDX-1:0]         i_waddr,
    input  logic signed [bce_pkg::W_COORD-1:0] i_wx,
    input  logic signed [bce_pkg::W_COORD-1:0] i_wy,
    input  logic signed [bce_pkg::W_COORD-1:0] i_wz,
    input  logic [bce_pkg::W_IDX-1:0]         i_raddr,
    input  logic [1:0]                        i_raxis,
    output logic signed [bce_pkg::W_COORD-1:0] o_rdata
);
    import bce_pkg::*;

    logic signed [W_COORD-1:0] r_mem_x [NSLOTS];
    logic signed [W_COORD-1:0] r_mem_y [NSLOTS];
    logic signed [W_COORD-1:0] r_mem_z [NSLOTS];
    logic signed [W_COORD-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wx;
            r_mem_y[i_waddr] <= i_wy;
            r_mem_z[i_waddr] <= i_wz;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_raxis)
            AXIS_X:  r_rdata <= r_mem_x[i_raddr];
            AXIS_Y:  r_rdata <= r_mem_y[i_raddr];
            default: r_rdata <= r_mem_z[i_raddr];
        endcase
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bce_mul.sv =====
// Shared multiplier with a registered product, used for interpolation and scaling.
// Depends on bce_pkg.
module bce_mul (
    input  logic                               i_clk,
    input  bce_pkg::t_msel                     i_sel,
    input  logic signed [bce_pkg::W_MA-1:0]    i_d,
    input  logic signed [bce_pkg::W_Q-1:0]     i_q0,
    input  logic [bce_pkg::W_T-1:0]            i_t,
    input  logic [bce_pkg::W_SCALE-1:0]        i_scale,
    output logic signed [bce_pkg::W_P-1:0]     o_prod
);
    import bce_pkg::*;

    logic signed [W_MA-1:0] op_a;
    logic signed [W_MB-1:0] op_b;
    logic signed [W_P-1:0]  r_prod;

    // Interpolation multiplies a difference by t; scaling multiplies the
    // remaining point by the derivative factor.
    always_comb begin
        if (i_sel == M_SCALE) begin
            op_a = W_MA'(i_q0);
            op_b = $signed(W_MB'(i_scale));
        end else begin
            op_a = i_d;
            op_b = $signed(W_MB'(i_t));
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= W_P'(op_a) * W_P'(op_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== design/bce_queue.sv =====
// Working point line of the evaluator: differences, interpolation and clipping.
// Depends on bce_pkg; takes its product from bce_mul.
module bce_queue (
    input  logic                                i_clk,
    input  bce_pkg::t_ctrl                      i_ctrl,
    input  logic signed [bce_pkg::W_COORD-1:0]  i_rdata,
    input  logic signed [bce_pkg::W_P-1:0]      i_prod,
    output logic signed [bce_pkg::W_Q-1:0]      o_q0,
    output logic signed [bce_pkg::W_MA-1:0]     o_d,
    output logic signed [bce_pkg::W_OUT-1:0]    o_res_x,
    output logic signed [bce_pkg::W_OUT-1:0]    o_res_y,
    output logic signed [bce_pkg::W_OUT-1:0]    o_res_z,
    output logic                                o_sat
);
    import bce_pkg::*;

    logic signed [W_Q-1:0]   r_q [NSLOTS];
    logic signed [W_OUT-1:0] r_res [3];
    logic [2:0]              r_sat;

    logic [W_P-1:0]          rnd;
    logic signed [W_Q-1:0]   lerp;
    logic [W_P-W_OUT:0]      prod_hi;
    logic                    fits;
    logic signed [W_OUT-1:0] clipped;

    assign o_q0 = r_q[0];
    assign o_d  = W_MA'(r_q[1]) - W_MA'(r_q[0]);

    // Round half up, then floor through the arithmetic shift.
    assign rnd  = i_prod + ROUND_HALF;
    assign lerp = r_q[0] + $signed(rnd[FRAC+W_Q-1:FRAC]);

    assign prod_hi = i_prod[W_P-1:W_OUT-1];
    assign fits    = (prod_hi == '0) || (prod_hi == '1);
    assign clipped = fits ? i_prod[W_OUT-1:0] : (i_prod[W_P-1] ? OUT_MIN : OUT_MAX);

    // Each pass shifts the line down by one and appends its new value after
    // the values still waiting, so only the first two entries are ever read.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.qop)
            Q_LOAD: begin
                r_q[i_ctrl.widx] <= W_Q'(i_rdata);
            end
            Q_DIFF: begin
                for (int i = 0; i < NSLOTS - 1; i++) begin
                    r_q[i] <= r_q[i+1];
                end
                r_q[i_ctrl.widx] <= W_Q'(o_d);
            end
            Q_LERP: begin
                for (int i = 0; i < NSLOTS - 1; i++) begin
                    r_q[i] <= r_q[i+1];
                end
                r_q[i_ctrl.widx] <= lerp;
            end
            Q_DROP: begin
                for (int i = 0; i < NSLOTS - 1; i++) begin
                    r_q[i] <= r_q[i+1];
                end
            end
            Q_SAT: begin
                r_res[i_ctrl.axis] <= clipped;
                r_sat[i_ctrl.axis] <= !fits;
            end
            default: begin
            end
        endcase
    end

    assign o_res_x = r_res[AXIS_X];
    assign o_res_y = r_res[AXIS_Y];
    assign o_res_z = r_res[AXIS_Z];
    assign o_sat   = |r_sat;

endmodule

// ===== design/bce_seq.sv =====
// Sequencer of the evaluator: walks load, difference, interpolation and
// scaling passes for each axis. Depends on bce_pkg.
module bce_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bce_pkg::W_FUNC-1:0]    i_func,
    input  logic [bce_pkg::W_T-1:0]       i_param_t,
    input  logic [bce_pkg::W_DEG-1:0]     i_degree,
    input  logic                          i_out_free,
    output bce_pkg::t_ctrl                o_ctrl,
    output logic [bce_pkg::W_T-1:0]       o_t,
    output logic [bce_pkg::W_SCALE-1:0]   o_scale
);
    import bce_pkg::*;

    t_state             r_state, n_state;
    logic [W_DEG-1:0]   r_n, n_n;
    logic [1:0]         r_k, n_k;
    logic [W_T-1:0]     r_t, n_t;
    logic [W_SCALE-1:0] r_scale, n_scale;
    logic [1:0]         r_axis, n_axis;
    logic [W_CNT-1:0]   r_ld, n_ld;
    logic [W_CNT-1:0]   r_len, n_len;
    logic [W_IDX-1:0]   r_step, n_step;
    logic [1:0]         r_dleft, n_dleft;
    logic               r_zero, n_zero;

    logic [W_DEG-1:0]   acc_n;
    logic [1:0]         acc_k;
    logic               pass_last;

    always_comb begin
        if (i_degree < DEGREE_MIN) begin
            acc_n = DEGREE_MIN;
        end else if (i_degree > W_DEG'(MAX_DEGREE)) begin
            acc_n = W_DEG'(MAX_DEGREE);
        end else begin
            acc_n = i_degree;
        end
    end

    assign acc_k     = 2'(i_func - FUNC_POS);
    assign pass_last = (W_CNT'(r_step) == r_len - W_CNT'(2));
    assign o_in_ready = (r_state == S_IDLE);
    assign o_t       = r_t;
    assign o_scale   = r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= DEGREE_RESET;
            r_k     <= '0;
            r_axis  <= AXIS_X;
            r_ld    <= '0;
            r_len   <= '0;
            r_step  <= '0;
            r_dleft <= '0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_k     <= n_k;
            r_axis  <= n_axis;
            r_ld    <= n_ld;
            r_len   <= n_len;
            r_step  <= n_step;
            r_dleft <= n_dleft;
            r_zero  <= n_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_scale <= n_scale;
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_k     = r_k;
        n_t     = r_t;
        n_scale = r_scale;
        n_axis  = r_axis;
        n_ld    = r_ld;
        n_len   = r_len;
        n_step  = r_step;
        n_dleft = r_dleft;
        n_zero  = r_zero;

        o_ctrl.qop      = Q_HOLD;
        o_ctrl.msel     = M_LERP;
        o_ctrl.axis     = r_axis;
        o_ctrl.widx     = W_IDX'(r_len - W_CNT'(1));
        o_ctrl.raddr    = r_ld[W_IDX-1:0];
        o_ctrl.out_load = 1'b0;
        o_ctrl.out_zero = r_zero;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_func inside {[FUNC_POS:FUNC_D3]})) begin
                    n_n     = acc_n;
                    n_k     = acc_k;
                    n_t     = (i_param_t > T_ONE) ? T_ONE : i_param_t;
                    n_scale = f_scale(acc_n, acc_k);
                    n_axis  = AXIS_X;
                    n_ld    = '0;
                    n_len   = W_CNT'(acc_n) + W_CNT'(1);
                    n_dleft = acc_k;
                    n_zero  = (W_DEG'(acc_k) > acc_n);
                    n_state = (W_DEG'(acc_k) > acc_n) ? S_OUT : S_LOAD;
                end
            end
            S_LOAD: begin
                o_ctrl.widx = W_IDX'(r_ld - W_CNT'(1));
                if (r_ld != '0) begin
                    o_ctrl.qop = Q_LOAD;
                end
                n_ld = r_ld + W_CNT'(1);
                if (r_ld == r_len) begin
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                n_step = '0;
                if (r_dleft != '0) begin
                    n_state = S_DIFF;
                end else if (r_len > W_CNT'(1)) begin
                    n_state = S_LMUL;
                end else begin
                    n_state = S_SMUL;
                end
            end
            S_DIFF: begin
                o_ctrl.qop = Q_DIFF;
                n_step = r_step + W_IDX'(1);
                if (pass_last) begin
                    n_dleft = r_dleft - 2'd1;
                    n_state = S_DROP;
                end
            end
            S_LMUL: begin
                o_ctrl.msel = M_LERP;
                n_state = S_LADD;
            end
            S_LADD: begin
                o_ctrl.qop = Q_LERP;
                n_step = r_step + W_IDX'(1);
                n_state = pass_last ? S_DROP : S_LMUL;
            end
            S_DROP: begin
                o_ctrl.qop = Q_DROP;
                n_len = r_len - W_CNT'(1);
                n_state = S_PASS;
            end
            S_SMUL: begin
                o_ctrl.msel = M_SCALE;
                n_state = S_SAT;
            end
            S_SAT: begin
                o_ctrl.qop = Q_SAT;
                if (r_axis == AXIS_Z) begin
                    n_state = S_OUT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_ld    = '0;
                    n_len   = W_CNT'(r_n) + W_CNT'(1);
                    n_dleft = r_k;
                    n_state = S_LOAD;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/bce_checker.sv =====
// Port-level checker of the Bezier curve evaluator, bound to the top level.
// Depends on bce_pkg and bezier_curve_evaluator_macros.svh.
`include "bezier_curve_evaluator_macros.svh"

module bce_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [bce_pkg::W_FUNC-1:0]    i_func,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [bce_pkg::W_OUT-1:0]     o_out_x,
    input logic [bce_pkg::W_OUT-1:0]     o_out_y,
    input logic [bce_pkg::W_OUT-1:0]     o_out_z,
    input logic                          o_saturated
);
    import bce_pkg::*;

    // A stalled result stays put.
    `BCE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z) && $stable(o_saturated), "result changed while stalled")

    // An evaluate item keeps the block busy.
    `BCE_ASSERT_NXT(a_eval_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_func == FUNC_POS || i_func == FUNC_D1 || i_func == FUNC_D2 || i_func == FUNC_D3), !o_in_ready, "ready after evaluate item")

    // A load item does not stall the input.
    `BCE_ASSERT_NXT(a_load_ready, i_clk, i_rst_n, i_in_valid && o_in_ready && i_func == FUNC_LOAD, o_in_ready, "not ready after load item")

    // A new result only appears at the end of an evaluation.
    `BCE_ASSERT_IMP(a_out_origin, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready), "result without evaluation")

endmodule

bind bezier_curve_evaluator bce_checker u_bce_checker (.*);
